/* design/lmrs_pkg.sv */
package lmrs_pkg;

	// Scroll text store depth.
	localparam int MAX_TEXT = 32;
	localparam int TEXT_IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int TEXT_CNT_W = $clog2(MAX_TEXT + 1);

	localparam int IMG_DIM = 5;
	localparam int ROW_W = 16;
	localparam int GLYPH_W = IMG_DIM * IMG_DIM;
	localparam int NUM_COLS = 9;
	localparam int NUM_SCAN = 3;
	localparam int SCAN_W = 2;

	// The leftmost visible column sits at bit 9 of a row register.
	localparam int LEFT_BIT = 9;

	localparam int BLINK_PERIOD = 100;
	localparam int SCROLL_PERIOD = 28;
	localparam int GLYPH_SHIFTS = 6;
	localparam int BLINK_CNT_W = $clog2(BLINK_PERIOD);
	localparam int SCROLL_CNT_W = $clog2(SCROLL_PERIOD);
	localparam int SHIFT_CNT_W = $clog2(GLYPH_SHIFTS);

	typedef enum logic [2:0] {
		CMD_TICK         = 3'd0,
		CMD_SET_PIXEL    = 3'd1,
		CMD_SHOW_GLYPH   = 3'd2,
		CMD_LOAD_GLYPH   = 3'd3,
		CMD_START_SCROLL = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [2:0]         pixel_x;
		logic [2:0]         pixel_y;
		logic [GLYPH_W-1:0] glyph_bits;
		logic               blink;
		logic [4:0]         glyph_index;
		logic [5:0]         text_length;
		logic               loop;
	} item_t;

	typedef struct packed {
		logic [NUM_SCAN-1:0] row_select;
		logic [NUM_COLS-1:0] col_levels;
	} result_t;

	// Image pixel (y*5+x) to matrix position: scan row in the high nibble,
	// column in the low nibble.
	localparam logic [7:0] PIX_MAP [GLYPH_W] = '{
		8'h00, 8'h13, 8'h01, 8'h14, 8'h02,
		8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h11, 8'h08, 8'h12, 8'h28, 8'h10,
		8'h07, 8'h06, 8'h05, 8'h04, 8'h03,
		8'h22, 8'h16, 8'h20, 8'h15, 8'h21
	};

endpackage

/* design/lmrs_ifs.sv */
interface lmrs_item_if import lmrs_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lmrs_result_if import lmrs_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/led_matrix_refresh_scroller.sv */
// An accepted item waits in the input stage until the state update takes it;
// a tick's result then sits in the result register until it is taken.
// Throughput: one item per cycle, set by the single input stage and the
// single result register; a stalled result register holds only ticks back.
// Reset (arst_n low, asynchronous) clears the image, counters and mode flags
// at once; the scroll text store is not cleared and must be loaded first.
module led_matrix_refresh_scroller import lmrs_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	lmrs_item_if.sink    command,
	lmrs_result_if.source drive
);

	// Input stage: one registered item waiting for the state update.
	logic  valid_s1;
	item_t item_s1;

	// Result register.
	logic    out_valid_q;
	result_t out_data_q;

	// Display state.
	logic [ROW_W-1:0]        rows_q [IMG_DIM];
	logic [SCAN_W-1:0]       scan_row_q;
	logic [15:0]             tick_count_q;
	logic [BLINK_CNT_W-1:0]  blink_mod_q;
	logic [SCROLL_CNT_W-1:0] scroll_mod_q;
	logic [15:0]             shift_count_q;
	logic [SHIFT_CNT_W-1:0]  shift_mod_q;
	logic [TEXT_CNT_W-1:0]   text_pos_q;
	logic [TEXT_CNT_W-1:0]   text_count_q;
	logic                    loop_on_q;
	logic                    scroll_on_q;
	logic                    blink_on_q;
	logic                    phase_q;
	logic                    running_q;

	// Scroll text store, written by load commands only.
	logic [GLYPH_W-1:0] text_glyphs_q [MAX_TEXT];

	// Next-state values.
	logic [ROW_W-1:0]        rows_d [IMG_DIM];
	logic [SCAN_W-1:0]       scan_row_d;
	logic [15:0]             tick_count_d;
	logic [BLINK_CNT_W-1:0]  blink_mod_d;
	logic [SCROLL_CNT_W-1:0] scroll_mod_d;
	logic [15:0]             shift_count_d;
	logic [SHIFT_CNT_W-1:0]  shift_mod_d;
	logic [TEXT_CNT_W-1:0]   text_pos_d;
	logic [TEXT_CNT_W-1:0]   text_count_d;
	logic                    loop_on_d;
	logic                    scroll_on_d;
	logic                    blink_on_d;
	logic                    phase_d;
	logic                    running_d;

	// Tick path intermediates.
	logic [SCAN_W-1:0]       scan_nx;
	logic [BLINK_CNT_W-1:0]  blink_mod_nx;
	logic [SCROLL_CNT_W-1:0] scroll_mod_nx;
	logic [SHIFT_CNT_W-1:0]  shift_mod_nx;
	logic                    phase_tick;
	logic                    shift_due;
	logic [NUM_COLS-1:0]     cols;
	logic [GLYPH_W-1:0]      glyph_rd;
	result_t                 result_d;

	// Handshake control.
	logic produce;
	logic out_free;
	logic step;
	logic accept_in;

	// Only a tick while running produces a result, so only such an item waits
	// on a full result register; everything else retires right away.
	assign produce   = valid_s1 && (item_s1.cmd == CMD_TICK) && running_q;
	assign out_free  = !out_valid_q || drive.ready;
	assign step      = valid_s1 && (!produce || out_free);
	assign accept_in = command.valid && command.ready;

	assign command.ready = !valid_s1 || step;
	assign drive.valid   = out_valid_q;
	assign drive.data    = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (command.ready) begin
			valid_s1 <= command.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= command.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && out_free) begin
			out_data_q <= result_d;
		end
	end

	// The modulo counters track tick_count and shift_count modulo their
	// periods. The 16-bit counters do not wrap on a period boundary, so a
	// wrap to zero also forces the residue back to zero.
	always_comb begin
		scan_nx = (scan_row_q >= SCAN_W'(NUM_SCAN - 1)) ? '0 : scan_row_q + 1'b1;

		if ((&tick_count_q) || blink_mod_q == BLINK_CNT_W'(BLINK_PERIOD - 1)) begin
			blink_mod_nx = '0;
		end else begin
			blink_mod_nx = blink_mod_q + 1'b1;
		end

		if ((&tick_count_q) || scroll_mod_q == SCROLL_CNT_W'(SCROLL_PERIOD - 1)) begin
			scroll_mod_nx = '0;
		end else begin
			scroll_mod_nx = scroll_mod_q + 1'b1;
		end

		if ((&shift_count_q) || shift_mod_q == SHIFT_CNT_W'(GLYPH_SHIFTS - 1)) begin
			shift_mod_nx = '0;
		end else begin
			shift_mod_nx = shift_mod_q + 1'b1;
		end

		phase_tick = phase_q ^ (blink_on_q && (blink_mod_nx == '0));
		shift_due  = scroll_on_q && (scroll_mod_nx == '0);
		glyph_rd   = text_glyphs_q[text_pos_q[TEXT_IDX_W-1:0]];
	end

	// Column levels for the row that this tick selects. The pixel map has no
	// two pixels on one matrix position, so each lit pixel clears its own pin.
	always_comb begin
		cols = '1;
		for (int y = 0; y < IMG_DIM; y++) begin
			for (int x = 0; x < IMG_DIM; x++) begin
				if (rows_q[y][LEFT_BIT - x] &&
					PIX_MAP[y * IMG_DIM + x][7:4] == {2'b00, scan_nx}) begin
					cols[PIX_MAP[y * IMG_DIM + x][3:0]] = 1'b0;
				end
			end
		end
		result_d.row_select = NUM_SCAN'(1) << scan_nx;
		result_d.col_levels = phase_tick ? cols : '1;
	end

	always_comb begin
		rows_d        = rows_q;
		scan_row_d    = scan_row_q;
		tick_count_d  = tick_count_q;
		blink_mod_d   = blink_mod_q;
		scroll_mod_d  = scroll_mod_q;
		shift_count_d = shift_count_q;
		shift_mod_d   = shift_mod_q;
		text_pos_d    = text_pos_q;
		text_count_d  = text_count_q;
		loop_on_d     = loop_on_q;
		scroll_on_d   = scroll_on_q;
		blink_on_d    = blink_on_q;
		phase_d       = phase_q;
		running_d     = running_q;

		unique case (item_s1.cmd)
			CMD_SET_PIXEL: begin
				// A column beyond the image lands on a hidden bit.
				if (item_s1.pixel_y < 3'(IMG_DIM)) begin
					rows_d[item_s1.pixel_y] = rows_q[item_s1.pixel_y] |
						(ROW_W'(1) << LEFT_BIT) >> item_s1.pixel_x;
				end
			end
			CMD_SHOW_GLYPH: begin
				for (int y = 0; y < IMG_DIM; y++) begin
					rows_d[y] = {rows_q[y][ROW_W-1:IMG_DIM],
						item_s1.glyph_bits[y * IMG_DIM +: IMG_DIM]} << IMG_DIM;
				end
				blink_on_d  = item_s1.blink;
				phase_d     = 1'b1;
				scroll_on_d = 1'b0;
				running_d   = 1'b1;
			end
			CMD_START_SCROLL: begin
				text_pos_d = '0;
				if (int'(item_s1.text_length) > MAX_TEXT) begin
					text_count_d = TEXT_CNT_W'(MAX_TEXT);
				end else begin
					text_count_d = TEXT_CNT_W'(item_s1.text_length);
				end
				loop_on_d   = item_s1.loop;
				scroll_on_d = 1'b1;
				phase_d     = 1'b1;
				blink_on_d  = 1'b0;
				running_d   = 1'b1;
			end
			CMD_TICK: begin
				if (running_q) begin
					scan_row_d   = scan_nx;
					tick_count_d = tick_count_q + 1'b1;
					blink_mod_d  = blink_mod_nx;
					scroll_mod_d = scroll_mod_nx;
					phase_d      = phase_tick;
					// A blanked tick never scrolls.
					if (phase_tick && shift_due) begin
						for (int y = 0; y < IMG_DIM; y++) begin
							rows_d[y] = rows_q[y] << 1;
						end
						shift_count_d = shift_count_q + 1'b1;
						shift_mod_d   = shift_mod_nx;
						// Every sixth shift opens a fresh glyph cell at the right, rewinds the text, or stops.
						if (shift_mod_nx == '0) begin
							if (text_pos_q < text_count_q) begin
								for (int y = 0; y < IMG_DIM; y++) begin
									rows_d[y][IMG_DIM-1:0] = glyph_rd[y * IMG_DIM +: IMG_DIM];
								end
								text_pos_d = text_pos_q + 1'b1;
							end else if (loop_on_q) begin
								text_pos_d = '0;
							end else begin
								running_d = 1'b0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < IMG_DIM; y++) begin
				rows_q[y] <= '0;
			end
			scan_row_q    <= SCAN_W'(NUM_SCAN - 1);
			tick_count_q  <= '0;
			blink_mod_q   <= '0;
			scroll_mod_q  <= '0;
			shift_count_q <= '0;
			shift_mod_q   <= '0;
			text_pos_q    <= '0;
			text_count_q  <= '0;
			loop_on_q     <= 1'b0;
			scroll_on_q   <= 1'b0;
			blink_on_q    <= 1'b0;
			phase_q       <= 1'b0;
			running_q     <= 1'b0;
		end else if (step) begin
			rows_q        <= rows_d;
			scan_row_q    <= scan_row_d;
			tick_count_q  <= tick_count_d;
			blink_mod_q   <= blink_mod_d;
			scroll_mod_q  <= scroll_mod_d;
			shift_count_q <= shift_count_d;
			shift_mod_q   <= shift_mod_d;
			text_pos_q    <= text_pos_d;
			text_count_q  <= text_count_d;
			loop_on_q     <= loop_on_d;
			scroll_on_q   <= scroll_on_d;
			blink_on_q    <= blink_on_d;
			phase_q       <= phase_d;
			running_q     <= running_d;
		end
	end

	// Slots past the end of the store are dropped.
	always_ff @(posedge clk) begin
		if (step && item_s1.cmd == CMD_LOAD_GLYPH &&
			int'(item_s1.glyph_index) < MAX_TEXT) begin
			text_glyphs_q[TEXT_IDX_W'(item_s1.glyph_index)] <= item_s1.glyph_bits;
		end
	end

`ifndef SYNTHESIS
	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(out_data_q.row_select))
		else $error("active row drive is not one-hot");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		text_pos_q <= text_count_q)
		else $error("text position ran past the text length");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_row_q != SCAN_W'(NUM_SCAN))
		else $error("scan row out of range");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && out_free) |=> out_valid_q)
		else $error("processed tick did not load a result");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_mod_q < BLINK_CNT_W'(BLINK_PERIOD) &&
		scroll_mod_q < SCROLL_CNT_W'(SCROLL_PERIOD) &&
		shift_mod_q < SHIFT_CNT_W'(GLYPH_SHIFTS))
		else $error("period counter out of range");
`endif

endmodule

/* test/tb_led_matrix_refresh_scroller.sv */
`timescale 1ns / 1ps

module tb_led_matrix_refresh_scroller;
	import lmrs_pkg::*;

	// Matrix position of each image pixel (y*5+x): scan row in the high
	// nibble, column pin in the low nibble.
	localparam logic [7:0] SCAN_POS [GLYPH_W] = '{
		8'h00, 8'h13, 8'h01, 8'h14, 8'h02,
		8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h11, 8'h08, 8'h12, 8'h28, 8'h10,
		8'h07, 8'h06, 8'h05, 8'h04, 8'h03,
		8'h22, 8'h16, 8'h20, 8'h15, 8'h21
	};

	// Item budget of the whole run; the last segment may run past it.
	localparam int TOTAL_ITEMS = 1750;
	// Enough running ticks to see the blink phase flip a couple of times.
	localparam int BLINK_TICKS = 250;
	localparam int QUIET_FROM = 1000;
	localparam int QUIET_TO = 2000;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cyc = 0;

	lmrs_item_if command_ch ();
	lmrs_result_if drive_ch ();

	led_matrix_refresh_scroller uut (
		.clk(clk),
		.arst_n(arst_n),
		.command(command_ch),
		.drive(drive_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Items waiting for the driver, and the drive results that the
	// accepted items are expected to produce, oldest first.
	item_t pending_items[$];
	result_t expected_drive[$];
	int error_count = 0;
	int queued_items = 0;
	bit [MAX_TEXT-1:0] slot_written = '0;

	// Shadow copy of the scanner state, updated once per accepted item.
	logic [ROW_W-1:0] img_rows [IMG_DIM];
	logic [1:0] cur_scan = 2'd2;
	logic [15:0] tick_total = '0;
	logic [15:0] shift_total = '0;
	logic [GLYPH_W-1:0] text_store [MAX_TEXT];
	int unsigned text_pos = 0;
	int unsigned text_len = 0;
	bit loop_mode = 1'b0;
	bit scrolling = 1'b0;
	bit blinking = 1'b0;
	bit lit_phase = 1'b0;
	bit pr_running = 1'b0;

	initial begin
		foreach (img_rows[i]) img_rows[i] = '0;
		foreach (text_store[i]) text_store[i] = '0;
	end

	// Each side holds back with a chance of 31 percent, except inside
	// one long window where both run flat out.
	function automatic bit hold_back();
		if (cyc >= QUIET_FROM && cyc < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 31;
	endfunction

	// Write a glyph into the low five bits of each row register.
	function automatic void paste_glyph(input logic [GLYPH_W-1:0] g);
		for (int y = 0; y < IMG_DIM; y++)
			img_rows[y] = {img_rows[y][ROW_W-1:5], g[5*y +: 5]};
	endfunction

	// One scroll step: the image moves left by a column, and every sixth
	// step either brings in the next glyph, rewinds the text, or stops.
	function automatic void scroll_step();
		for (int y = 0; y < IMG_DIM; y++)
			img_rows[y] = img_rows[y] << 1;
		shift_total = shift_total + 16'd1;
		if (shift_total % GLYPH_SHIFTS == 0) begin
			if (text_pos < text_len && text_pos < MAX_TEXT) begin
				paste_glyph(text_store[text_pos]);
				text_pos++;
			end else if (loop_mode) begin
				text_pos = 0;
			end else begin
				pr_running = 1'b0;
			end
		end
	endfunction

	// Apply one accepted item to the shadow state. Returns 1 when the item
	// is a tick that produces a drive result, which is placed in res.
	function automatic bit predict_drive(input item_t it, output result_t res);
		logic [8:0] cols;
		logic [7:0] rc;
		res = '0;
		case (it.cmd)
			CMD_SET_PIXEL: begin
				if (it.pixel_y < IMG_DIM)
					img_rows[it.pixel_y] = img_rows[it.pixel_y] | (16'h200 >> it.pixel_x);
				return 1'b0;
			end
			CMD_SHOW_GLYPH: begin
				paste_glyph(it.glyph_bits);
				for (int y = 0; y < IMG_DIM; y++)
					img_rows[y] = img_rows[y] << 5;
				blinking = it.blink;
				lit_phase = 1'b1;
				scrolling = 1'b0;
				pr_running = 1'b1;
				return 1'b0;
			end
			CMD_LOAD_GLYPH: begin
				if (it.glyph_index < MAX_TEXT)
					text_store[it.glyph_index] = it.glyph_bits;
				return 1'b0;
			end
			CMD_START_SCROLL: begin
				text_pos = 0;
				text_len = (it.text_length > MAX_TEXT) ? MAX_TEXT : it.text_length;
				loop_mode = it.loop;
				scrolling = 1'b1;
				lit_phase = 1'b1;
				blinking = 1'b0;
				pr_running = 1'b1;
				return 1'b0;
			end
			CMD_TICK: begin
				if (!pr_running)
					return 1'b0;
			end
			default: return 1'b0;
		endcase

		cur_scan = (cur_scan >= 2'd2) ? 2'd0 : cur_scan + 2'd1;
		tick_total = tick_total + 16'd1;
		res.row_select = 3'b001 << cur_scan;
		if (blinking && tick_total % BLINK_PERIOD == 0)
			lit_phase = !lit_phase;
		if (!lit_phase) begin
			// Dark half of a blink: all columns high, no scroll this tick.
			res.col_levels = 9'h1ff;
			return 1'b1;
		end

		cols = 9'h1ff;
		for (int y = 0; y < IMG_DIM; y++) begin
			for (int x = 0; x < IMG_DIM; x++) begin
				if (img_rows[y][LEFT_BIT - x]) begin
					rc = SCAN_POS[y * IMG_DIM + x];
					if (rc[7:4] == cur_scan)
						cols[rc[3:0]] = ~cols[rc[3:0]];
				end
			end
		end
		res.col_levels = cols;

		if (scrolling && tick_total % SCROLL_PERIOD == 0)
			scroll_step();
		return 1'b1;
	endfunction

	// Number of text slots written in a row from slot 0. A scroll text is
	// never longer than this, so no unwritten slot is ever read.
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < MAX_TEXT && slot_written[n])
			n++;
		return n;
	endfunction

	// An item of the given command with every other field random in range.
	// Scroll lengths lean short so that the end of the text is reached often.
	function automatic item_t rand_item(input cmd_t c);
		item_t it;
		int p;
		p = written_prefix();
		it.cmd = c;
		it.pixel_x = 3'($urandom_range(IMG_DIM - 1));
		it.pixel_y = 3'($urandom_range(IMG_DIM - 1));
		it.glyph_bits = GLYPH_W'($urandom);
		it.blink = 1'($urandom);
		it.glyph_index = 5'($urandom);
		if ($urandom_range(3) == 0)
			it.text_length = 6'($urandom_range(p));
		else
			it.text_length = 6'($urandom_range((p < 3) ? p : 3));
		it.loop = 1'($urandom);
		return it;
	endfunction

	function automatic void queue_item(input item_t it);
		if (it.cmd == CMD_LOAD_GLYPH)
			slot_written[it.glyph_index] = 1'b1;
		pending_items.push_back(it);
		queued_items++;
	endfunction

	// A run of ticks with the odd pixel write mixed in. The run is cut
	// short once the item budget of the whole test is used up.
	function automatic void queue_ticks(input int n, input int pixel_pct);
		for (int i = 0; i < n && queued_items < TOTAL_ITEMS; i++) begin
			if ($urandom_range(99) < pixel_pct)
				queue_item(rand_item(CMD_SET_PIXEL));
			else
				queue_item(rand_item(CMD_TICK));
		end
	endfunction

	function automatic cmd_t rand_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 50) return CMD_TICK;
		if (r < 65) return CMD_SET_PIXEL;
		if (r < 75) return CMD_SHOW_GLYPH;
		if (r < 90) return CMD_LOAD_GLYPH;
		return CMD_START_SCROLL;
	endfunction

	// Block until every queued item has been taken by the block. Polled on
	// the falling edge so the handshake signals have settled.
	task automatic wait_drained();
		while (pending_items.size() != 0 || command_ch.valid)
			@(negedge clk);
	endtask

	// Driver: presents the next pending item whenever the channel is free,
	// and updates the shadow state for each item the block accepts.
	result_t drive_pred;
	bit drive_has;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_ch.valid <= 1'b0;
			command_ch.data <= '0;
		end else begin
			if (command_ch.valid && command_ch.ready) begin
				drive_has = predict_drive(command_ch.data, drive_pred);
				if (drive_has)
					expected_drive.push_back(drive_pred);
			end
			if (!command_ch.valid || command_ch.ready) begin
				if (pending_items.size() != 0 && !hold_back()) begin
					command_ch.valid <= 1'b1;
					command_ch.data <= pending_items.pop_front();
				end else begin
					command_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes drive results with a randomly stalling ready and
	// compares each against the oldest expected one.
	result_t drive_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_ch.ready <= 1'b0;
		end else begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (expected_drive.size() == 0) begin
					$error("unexpected drive result: row_select %0h col_levels %0h",
						drive_ch.data.row_select, drive_ch.data.col_levels);
					error_count++;
				end else begin
					drive_want = expected_drive.pop_front();
					if (drive_ch.data.row_select !== drive_want.row_select) begin
						$error("row_select mismatch: expected %0h, actual %0h",
							drive_want.row_select, drive_ch.data.row_select);
						error_count++;
					end
					if (drive_ch.data.col_levels !== drive_want.col_levels) begin
						$error("col_levels mismatch: expected %0h, actual %0h",
							drive_want.col_levels, drive_ch.data.col_levels);
						error_count++;
					end
				end
			end
			drive_ch.ready <= !hold_back();
		end
	end

	// Stimulus: reset, a short directed list, a blinking run over a few
	// blink periods, then random segments until the item budget is spent.
	item_t it;
	int sel;

	initial begin
		arst_n = 1'b0;

		// A tick before anything has been shown is dropped silently.
		queue_item(rand_item(CMD_TICK));

		// Corner pixels of the image.
		it = rand_item(CMD_SET_PIXEL);
		it.pixel_x = 3'd0;
		it.pixel_y = 3'd0;
		queue_item(it);
		it.pixel_x = 3'd4;
		it.pixel_y = 3'd4;
		queue_item(it);
		it.pixel_x = 3'd4;
		it.pixel_y = 3'd0;
		queue_item(it);

		// Full glyph, steady: one tick per scan row lights everything.
		it = rand_item(CMD_SHOW_GLYPH);
		it.glyph_bits = '1;
		it.blink = 1'b0;
		queue_item(it);
		queue_ticks(3, 0);

		// Empty glyph with blink on, then a pixel drawn on top of it.
		it = rand_item(CMD_SHOW_GLYPH);
		it.glyph_bits = '0;
		it.blink = 1'b1;
		queue_item(it);
		it = rand_item(CMD_SET_PIXEL);
		it.pixel_x = 3'd0;
		it.pixel_y = 3'd4;
		queue_item(it);
		queue_ticks(3, 0);

		// Text slots at both ends of the store.
		it = rand_item(CMD_LOAD_GLYPH);
		it.glyph_index = 5'd0;
		it.glyph_bits = '1;
		queue_item(it);
		it.glyph_index = 5'd31;
		it.glyph_bits = '0;
		queue_item(it);
		it.glyph_index = 5'd1;
		it.glyph_bits = 25'h0aaaaaa;
		queue_item(it);

		// Looping scroll, then an empty non-looping text.
		it = rand_item(CMD_START_SCROLL);
		it.text_length = 6'd2;
		it.loop = 1'b1;
		queue_item(it);
		queue_ticks(3, 0);
		it.text_length = 6'd0;
		it.loop = 1'b0;
		queue_item(it);
		queue_ticks(2, 0);

		// Fill the whole text store so any length, the full one included,
		// can be scrolled from here on.
		for (int i = 0; i < MAX_TEXT; i++) begin
			it = rand_item(CMD_LOAD_GLYPH);
			it.glyph_index = 5'(i);
			queue_item(it);
		end

		// Blink stays on long enough for the phase to flip more than once.
		it = rand_item(CMD_SHOW_GLYPH);
		it.blink = 1'b1;
		queue_item(it);
		queue_ticks(BLINK_TICKS, 1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (queued_items < TOTAL_ITEMS) begin
			wait_drained();
			sel = $urandom_range(99);
			if (sel < 50) begin
				// Scroll segment, often long enough to reach the end of short texts.
				repeat ($urandom_range(3))
					queue_item(rand_item(CMD_LOAD_GLYPH));
				repeat ($urandom_range(2))
					queue_item(rand_item(CMD_SET_PIXEL));
				queue_item(rand_item(CMD_START_SCROLL));
				queue_ticks($urandom_range(150, 700), 3);
			end else if (sel < 75) begin
				queue_item(rand_item(CMD_SHOW_GLYPH));
				queue_ticks($urandom_range(50, 400), 3);
			end else begin
				// Noise: any command in any order.
				if (!pr_running)
					queue_item(rand_item($urandom_range(1) ? CMD_SHOW_GLYPH
						: CMD_START_SCROLL));
				repeat ($urandom_range(20, 60))
					queue_item(rand_item(rand_cmd()));
			end
		end

		wait_drained();
		while (expected_drive.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
